// ----- src/path_curvature_heading_core_defines.svh -----
// Assertion macros shared by the checker of path_curvature_heading_core.
// Depends on nothing; the including file provides clk and rst_n.
`ifndef PATH_CURVATURE_HEADING_CORE_DEFINES_SVH
`define PATH_CURVATURE_HEADING_CORE_DEFINES_SVH

// Check a consequent in the same cycle as its antecedent
`define PCH_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequent in the cycle after its antecedent
`define PCH_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/pch_pkg.sv -----
// Shared types, widths and the arctangent table for the path curvature core.
// Depends on nothing.
`default_nettype none

package pch_pkg;

    localparam int COORD_W      = 24;
    localparam int CORDIC_STEPS = 16;
    localparam int DIFF_W       = COORD_W + 1;
    localparam int D2_W         = COORD_W + 2;
    localparam int PRESCALE     = 60 - COORD_W;
    localparam int NORM_BIT     = 15;
    localparam int K_W          = 5;
    localparam int MUL_W        = 34;
    localparam int PROD_W       = 2 * MUL_W;
    localparam int C_W          = D2_W + 17;
    localparam int MAG_W        = C_W - 1;
    localparam int EXP_BASE     = 42;
    localparam int NUM_W        = MAG_W + EXP_BASE;
    localparam int CNT_W        = 7;
    localparam int Q_W          = 33;

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic                      final_point;
    } pch_point_t;

    typedef struct packed {
        logic signed [15:0] heading;
        logic signed [31:0] bend;
        logic               degenerate;
        logic               short_path;
        logic               path_done;
        logic               run_last;
    } pch_result_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SHORT,
        ST_START,
        ST_NORM,
        ST_MUL,
        ST_SQRT,
        ST_DEN,
        ST_DIV,
        ST_CORDIC,
        ST_FINISH,
        ST_EMIT
    } pch_state_t;

    // atan(2^-i) with 2^32 = 2*pi
    function automatic logic [31:0] atan_entry(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:    v = 32'h20000000;
            5'd1:    v = 32'h12E4051E;
            5'd2:    v = 32'h09FB385B;
            5'd3:    v = 32'h051111D4;
            5'd4:    v = 32'h028B0D43;
            5'd5:    v = 32'h0145D7E1;
            5'd6:    v = 32'h00A2F61E;
            5'd7:    v = 32'h00517C55;
            5'd8:    v = 32'h0028BE53;
            5'd9:    v = 32'h00145F2F;
            5'd10:   v = 32'h000A2F98;
            5'd11:   v = 32'h000517CC;
            5'd12:   v = 32'h00028BE6;
            5'd13:   v = 32'h000145F3;
            5'd14:   v = 32'h0000A2F9;
            5'd15:   v = 32'h0000517D;
            5'd16:   v = 32'h000028BE;
            5'd17:   v = 32'h0000145F;
            5'd18:   v = 32'h00000A30;
            5'd19:   v = 32'h00000518;
            5'd20:   v = 32'h0000028C;
            5'd21:   v = 32'h00000146;
            5'd22:   v = 32'h000000A3;
            5'd23:   v = 32'h00000051;
            default: v = 32'h0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ----- src/path_curvature_heading_core.sv -----
// Heading and curvature of a streamed path, one shared iterative datapath.
// Depends on pch_pkg.
//
// channel  | valid          | stall          | word
// point    | point_valid    | point_stall    | point  (pch_point_t)
// result   | result_valid   | result_stall   | result (pch_result_t)
//
// A point that completes no result leaves the core idle. A computed result
// runs through the normalize shifts, the multiply steps, 32 square root steps,
// the denominator multiply, 84 restoring divide steps and CORDIC_STEPS
// rotations. Short-path words load in turn as the output register frees.
// A result-yielding point raises point_stall until its last word is loaded in
// the output register. Reset clears the sequencer and path count.
`default_nettype none

module path_curvature_heading_core
    import pch_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        point_valid,
    output logic             point_stall,
    input  wire pch_point_t  point,
    output logic             result_valid,
    input  wire logic        result_stall,
    output pch_result_t      result
);

    pch_state_t state_reg, state_next;
    logic [1:0] seen_reg;
    logic signed [COORD_W-1:0] older_x_reg, older_y_reg, newer_x_reg, newer_y_reg;
    logic fin_reg, first_job_reg, dup_reg, short_two_reg;
    logic signed [DIFF_W-1:0] jdx_reg, jdy_reg, bdx_reg, bdy_reg;
    logic signed [D2_W-1:0] d2x_reg, d2y_reg;
    logic [DIFF_W-1:0] m_reg, exm_reg, eym_reg;
    logic [D2_W-1:0] fxm_reg, fym_reg;
    logic sx_reg, sy_reg, sfx_reg, sfy_reg;
    logic [K_W-1:0] k_reg;
    logic [2:0] mstep_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [C_W-1:0] c_reg;
    logic [31:0] q_reg;
    logic [63:0] sv_reg, sres_reg, sbit_reg;
    logic [62:0] den_reg;
    logic [NUM_W-1:0] num_reg;
    logic [63:0] rem_reg;
    logic [Q_W-1:0] quo_reg;
    logic ovf_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic signed [63:0] cx_reg, cy_reg;
    logic [31:0] acc_reg;
    logic [15:0] head_reg;
    logic [31:0] bend_reg;
    logic deg_reg;
    logic out_valid_reg;
    pch_result_t out_word_reg;

    logic accept, out_free, out_load;
    pch_result_t out_word_next;

    // Window arithmetic at accept
    logic signed [D2_W-1:0] d2x_c, d2y_c;
    logic signed [DIFF_W-1:0] dxa_c, dya_c, dxb_c, dyb_c;

    assign accept      = point_valid && (state_reg == ST_IDLE);
    assign point_stall = (state_reg != ST_IDLE);
    assign out_free    = !out_valid_reg || !result_stall;
    assign result_valid = out_valid_reg;
    assign result       = out_word_reg;

    assign d2x_c = D2_W'(point.point_x) + D2_W'(older_x_reg) - (D2_W'(newer_x_reg) <<< 1);
    assign d2y_c = D2_W'(point.point_y) + D2_W'(older_y_reg) - (D2_W'(newer_y_reg) <<< 1);
    assign dxa_c = DIFF_W'(newer_x_reg) - DIFF_W'(older_x_reg);
    assign dya_c = DIFF_W'(newer_y_reg) - DIFF_W'(older_y_reg);
    assign dxb_c = DIFF_W'(point.point_x) - DIFF_W'(newer_x_reg);
    assign dyb_c = DIFF_W'(point.point_y) - DIFF_W'(newer_y_reg);

    // Magnitudes of the job operands
    logic [DIFF_W-1:0] jdx_mag, jdy_mag;
    logic [D2_W-1:0] d2x_mag, d2y_mag;
    assign jdx_mag = jdx_reg[DIFF_W-1] ? DIFF_W'(-jdx_reg) : DIFF_W'(jdx_reg);
    assign jdy_mag = jdy_reg[DIFF_W-1] ? DIFF_W'(-jdy_reg) : DIFF_W'(jdy_reg);
    assign d2x_mag = d2x_reg[D2_W-1] ? D2_W'(-d2x_reg) : D2_W'(d2x_reg);
    assign d2y_mag = d2y_reg[D2_W-1] ? D2_W'(-d2y_reg) : D2_W'(d2y_reg);

    // CORDIC start vector, quadrant folded into the right half plane
    logic signed [63:0] dx64, dy64, x0_c, y0_c;
    logic [31:0] acc0_c;
    assign dx64 = 64'(jdx_reg);
    assign dy64 = 64'(jdy_reg);
    always_comb
    begin
        if (jdx_reg < 0)
        begin
            if (jdy_reg >= 0)
            begin
                x0_c = dy64;   y0_c = -dx64; acc0_c = 32'h40000000;
            end
            else
            begin
                x0_c = -dy64;  y0_c = dx64;  acc0_c = 32'hC0000000;
            end
        end
        else
        begin
            x0_c = dx64; y0_c = dy64; acc0_c = 32'h0;
        end
    end

    // Shared multiplier with signed primed operands
    logic signed [MUL_W-1:0] ex_s, ey_s, fx_s, fy_s, mul_a, mul_b;
    logic signed [PROD_W-1:0] mul_p;
    assign ex_s = sx_reg  ? -$signed(MUL_W'(exm_reg)) : $signed(MUL_W'(exm_reg));
    assign ey_s = sy_reg  ? -$signed(MUL_W'(eym_reg)) : $signed(MUL_W'(eym_reg));
    assign fx_s = sfx_reg ? -$signed(MUL_W'(fxm_reg)) : $signed(MUL_W'(fxm_reg));
    assign fy_s = sfy_reg ? -$signed(MUL_W'(fym_reg)) : $signed(MUL_W'(fym_reg));
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (state_reg == ST_DEN)
        begin
            mul_a = $signed(MUL_W'(q_reg));
            mul_b = $signed(MUL_W'(sres_reg[31:0]));
        end
        else
        begin
            case (mstep_reg)
                3'd0:    begin mul_a = fy_s; mul_b = ex_s; end
                3'd1:    begin mul_a = fx_s; mul_b = ey_s; end
                3'd2:    begin mul_a = ex_s; mul_b = ex_s; end
                3'd3:    begin mul_a = ey_s; mul_b = ey_s; end
                default: begin mul_a = '0;   mul_b = '0;   end
            endcase
        end
    end
    assign mul_p = mul_a * mul_b;

    logic [31:0] qsum_c;
    assign qsum_c = q_reg + prod_reg[31:0];

    // Square root step
    logic [63:0] stry_c;
    assign stry_c = sres_reg + sbit_reg;

    // Divide step
    logic [63:0] rem_sh_c;
    logic rem_ge_c;
    logic [MAG_W-1:0] cmag_c;
    logic [5:0] e_amt_c;
    assign rem_sh_c = {rem_reg[62:0], num_reg[NUM_W-1]};
    assign rem_ge_c = (rem_sh_c >= {1'b0, den_reg});
    assign cmag_c   = c_reg[C_W-1] ? MAG_W'(-c_reg) : MAG_W'(c_reg);
    assign e_amt_c  = 6'(EXP_BASE) - 6'(k_reg);

    // CORDIC step
    logic signed [63:0] xs_c, ys_c;
    assign xs_c = cx_reg >>> cnt_reg[4:0];
    assign ys_c = cy_reg >>> cnt_reg[4:0];

    // Saturated bend from the quotient
    logic neg_c, sat_c;
    logic [Q_W-1:0] limit_c;
    logic [31:0] bend_c;
    logic [31:0] acc_rnd_c;
    assign neg_c   = c_reg[C_W-1];
    assign limit_c = neg_c ? Q_W'(33'h080000000) : Q_W'(33'h07FFFFFFF);
    assign sat_c   = ovf_reg || (quo_reg > limit_c);
    always_comb
    begin
        if (den_reg == '0)
            bend_c = '0;
        else if (sat_c)
            bend_c = neg_c ? 32'h80000000 : 32'h7FFFFFFF;
        else
            bend_c = neg_c ? -quo_reg[31:0] : quo_reg[31:0];
    end
    assign acc_rnd_c = acc_reg + 32'h00008000;

    // Sequencer: next state and output word
    always_comb
    begin
        state_next    = state_reg;
        out_load      = 1'b0;
        out_word_next = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (seen_reg < 2'd2)
                    begin
                        if (point.final_point)
                            state_next = ST_SHORT;
                    end
                    else
                        state_next = ST_START;
                end
            end
            ST_SHORT:
            begin
                if (out_free)
                begin
                    out_load                 = 1'b1;
                    out_word_next.short_path = 1'b1;
                    out_word_next.path_done  = !short_two_reg;
                    out_word_next.run_last   = !short_two_reg;
                    if (!short_two_reg)
                        state_next = ST_IDLE;
                end
            end
            ST_START:
            begin
                if (jdx_reg == '0 && jdy_reg == '0)
                    state_next = ST_EMIT;
                else
                    state_next = ST_NORM;
            end
            ST_NORM:
            begin
                if (m_reg[DIFF_W-1:NORM_BIT] == '0)
                    state_next = ST_MUL;
            end
            ST_MUL:
            begin
                if (mstep_reg == 3'd4)
                    state_next = ST_SQRT;
            end
            ST_SQRT:
            begin
                if (cnt_reg == CNT_W'(31))
                    state_next = ST_DEN;
            end
            ST_DEN:
            begin
                if (mstep_reg == 3'd1)
                    state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (cnt_reg == CNT_W'(NUM_W - 1))
                    state_next = ST_CORDIC;
            end
            ST_CORDIC:
            begin
                if (cnt_reg == CNT_W'(CORDIC_STEPS - 1))
                    state_next = ST_FINISH;
            end
            ST_FINISH:
                state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_load                 = 1'b1;
                    out_word_next.heading    = head_reg;
                    out_word_next.bend       = bend_reg;
                    out_word_next.degenerate = deg_reg;
                    if (first_job_reg)
                        state_next = ST_START;
                    else if (dup_reg)
                    begin
                        out_word_next.path_done = 1'b1;
                        out_word_next.run_last  = 1'b1;
                        state_next              = ST_IDLE;
                    end
                    else
                    begin
                        out_word_next.run_last = !fin_reg;
                        if (!fin_reg)
                            state_next = ST_IDLE;
                    end
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Hold state and control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            seen_reg      <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!result_stall)
                out_valid_reg <= 1'b0;
            if (accept)
            begin
                if (point.final_point)
                    seen_reg <= 2'd0;
                else if (seen_reg != 2'd3)
                    seen_reg <= seen_reg + 2'd1;
            end
        end
    end

    // Advance the datapath
    always_ff @(posedge clk)
    begin
        if (out_load)
            out_word_reg <= out_word_next;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    older_x_reg   <= newer_x_reg;
                    older_y_reg   <= newer_y_reg;
                    newer_x_reg   <= point.point_x;
                    newer_y_reg   <= point.point_y;
                    fin_reg       <= point.final_point;
                    short_two_reg <= (seen_reg == 2'd1);
                    first_job_reg <= (seen_reg == 2'd2);
                    dup_reg       <= 1'b0;
                    d2x_reg       <= d2x_c;
                    d2y_reg       <= d2y_c;
                    bdx_reg       <= dxb_c;
                    bdy_reg       <= dyb_c;
                    jdx_reg       <= (seen_reg == 2'd2) ? dxa_c : dxb_c;
                    jdy_reg       <= (seen_reg == 2'd2) ? dya_c : dyb_c;
                end
            end
            ST_SHORT:
            begin
                if (out_free)
                    short_two_reg <= 1'b0;
            end
            ST_START:
            begin
                head_reg  <= '0;
                bend_reg  <= '0;
                deg_reg   <= 1'b1;
                m_reg     <= (jdx_mag > jdy_mag) ? jdx_mag : jdy_mag;
                exm_reg   <= jdx_mag;
                eym_reg   <= jdy_mag;
                fxm_reg   <= d2x_mag;
                fym_reg   <= d2y_mag;
                sx_reg    <= jdx_reg[DIFF_W-1];
                sy_reg    <= jdy_reg[DIFF_W-1];
                sfx_reg   <= d2x_reg[D2_W-1];
                sfy_reg   <= d2y_reg[D2_W-1];
                k_reg     <= '0;
                mstep_reg <= '0;
                cx_reg    <= x0_c <<< PRESCALE;
                cy_reg    <= y0_c <<< PRESCALE;
                acc_reg   <= acc0_c;
            end
            ST_NORM:
            begin
                if (m_reg[DIFF_W-1:NORM_BIT] != '0)
                begin
                    m_reg   <= m_reg >> 1;
                    exm_reg <= exm_reg >> 1;
                    eym_reg <= eym_reg >> 1;
                    fxm_reg <= fxm_reg >> 1;
                    fym_reg <= fym_reg >> 1;
                    k_reg   <= k_reg + K_W'(1);
                end
            end
            ST_MUL:
            begin
                prod_reg  <= mul_p;
                mstep_reg <= (mstep_reg == 3'd4) ? 3'd0 : mstep_reg + 3'd1;
                case (mstep_reg)
                    3'd1:    c_reg <= C_W'(prod_reg);
                    3'd2:    c_reg <= c_reg - C_W'(prod_reg);
                    3'd3:    q_reg <= prod_reg[31:0];
                    3'd4:
                    begin
                        q_reg     <= qsum_c;
                        sv_reg    <= {qsum_c, 32'h0};
                        sres_reg  <= '0;
                        sbit_reg  <= 64'h4000000000000000;
                        cnt_reg   <= '0;
                    end
                    default: ;
                endcase
            end
            ST_SQRT:
            begin
                if (sv_reg >= stry_c)
                begin
                    sv_reg   <= sv_reg - stry_c;
                    sres_reg <= (sres_reg >> 1) + sbit_reg;
                end
                else
                    sres_reg <= sres_reg >> 1;
                sbit_reg <= sbit_reg >> 2;
                cnt_reg  <= cnt_reg + CNT_W'(1);
            end
            ST_DEN:
            begin
                mstep_reg <= mstep_reg + 3'd1;
                if (mstep_reg == 3'd0)
                    prod_reg <= mul_p;
                else
                begin
                    den_reg <= prod_reg[62:0];
                    num_reg <= NUM_W'(cmag_c) << e_amt_c;
                    rem_reg <= '0;
                    quo_reg <= '0;
                    ovf_reg <= 1'b0;
                    cnt_reg <= '0;
                end
            end
            ST_DIV:
            begin
                rem_reg <= rem_ge_c ? (rem_sh_c - {1'b0, den_reg}) : rem_sh_c;
                quo_reg <= {quo_reg[Q_W-2:0], rem_ge_c};
                ovf_reg <= ovf_reg | quo_reg[Q_W-1];
                num_reg <= num_reg << 1;
                cnt_reg <= (cnt_reg == CNT_W'(NUM_W - 1)) ? '0 : cnt_reg + CNT_W'(1);
            end
            ST_CORDIC:
            begin
                if (!cy_reg[63])
                begin
                    cx_reg  <= cx_reg + ys_c;
                    cy_reg  <= cy_reg - xs_c;
                    acc_reg <= acc_reg + atan_entry(cnt_reg[4:0]);
                end
                else
                begin
                    cx_reg  <= cx_reg - ys_c;
                    cy_reg  <= cy_reg + xs_c;
                    acc_reg <= acc_reg - atan_entry(cnt_reg[4:0]);
                end
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            ST_FINISH:
            begin
                head_reg <= acc_rnd_c[31:16];
                bend_reg <= bend_c;
                deg_reg  <= 1'b0;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    if (first_job_reg)
                    begin
                        first_job_reg <= 1'b0;
                        jdx_reg       <= bdx_reg;
                        jdy_reg       <= bdy_reg;
                    end
                    else if (!dup_reg && fin_reg)
                        dup_reg <= 1'b1;
                end
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

// ----- src/pch_checker.sv -----
// Port-level checks on path_curvature_heading_core, bound into each instance of it.
// Depends on pch_pkg and path_curvature_heading_core_defines.svh.
`default_nettype none
`include "path_curvature_heading_core_defines.svh"

module pch_checker
    import pch_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        point_valid,
    input wire logic        point_stall,
    input wire pch_point_t  point,
    input wire logic        result_valid,
    input wire logic        result_stall,
    input wire pch_result_t result
);

    logic in_wait, out_wait, short_ok, degen_ok;
    assign in_wait  = point_valid && point_stall;
    assign out_wait = result_valid && result_stall;
    assign short_ok = result.bend == 0 && result.heading == 0 && !result.degenerate;
    assign degen_ok = result.bend == 0 && result.heading == 0 && !result.short_path;

    // Short-path words carry zero values
    `PCH_ASSERT_NOW(a_short_zero, result_valid && result.short_path, short_ok, "short word not zero")

    // Degenerate words carry zero heading and bend
    `PCH_ASSERT_NOW(a_degen_zero, result_valid && result.degenerate, degen_ok, "degen word not zero")

    // The final point's word closes the run
    `PCH_ASSERT_NOW(a_done_last, result_valid && result.path_done, result.run_last, "done not last")

    // Hold a stalled word
    `PCH_ASSERT_NEXT(a_out_hold, out_wait, result_valid && $stable(result), "stalled result changed")

    // Hold a stalled point word
    `PCH_ASSERT_NEXT(a_in_hold, in_wait, point_valid && $stable(point), "stalled point changed")

endmodule

bind path_curvature_heading_core pch_checker u_pch_checker (.*);

`default_nettype wire
